// ===== rtl/yuv2rgb_pkg.sv =====
// Shared constants, types and functions for the YUV422 to RGB565 converter.
`default_nettype none

package yuv2rgb_pkg;

  // Width of the intermediate signed channel sums (covers about -71k..137k).
  localparam int unsigned SumW = 20;

  localparam logic [2:0] BYTE_ORDER_RESET = 3'd4;

  localparam logic signed [SumW-1:0] COEF_Y    = 20'sd298;
  localparam logic signed [SumW-1:0] COEF_RV   = 20'sd409;
  localparam logic signed [SumW-1:0] COEF_GU   = 20'sd100;
  localparam logic signed [SumW-1:0] COEF_GV   = 20'sd208;
  localparam logic signed [SumW-1:0] COEF_BU   = 20'sd516;
  localparam logic signed [SumW-1:0] LUMA_OFS  = 20'sd16;
  localparam logic signed [SumW-1:0] CHROMA_OFS = 20'sd128;
  localparam logic signed [SumW-1:0] ROUND_OFS = 20'sd128;
  localparam logic signed [SumW-9:0] CHAN_MAX  = 12'sd255;

  typedef logic signed [SumW-1:0] sum_t;

  // Byte positions of each sample within the 32-bit word.
  typedef struct packed {
    logic [1:0] y0;
    logic [1:0] u;
    logic [1:0] y1;
    logic [1:0] v;
  } lane_map_t;

  function automatic lane_map_t lane_map(input logic [2:0] order);
    lane_map_t m;
    case (order)
      3'd0:    m = '{y0: 2'd1, u: 2'd0, y1: 2'd3, v: 2'd2};
      3'd1:    m = '{y0: 2'd0, u: 2'd1, y1: 2'd2, v: 2'd3};
      3'd2:    m = '{y0: 2'd0, u: 2'd3, y1: 2'd2, v: 2'd1};
      3'd3:    m = '{y0: 2'd1, u: 2'd2, y1: 2'd3, v: 2'd0};
      3'd4:    m = '{y0: 2'd2, u: 2'd3, y1: 2'd0, v: 2'd1};
      3'd5:    m = '{y0: 2'd3, u: 2'd2, y1: 2'd1, v: 2'd0};
      3'd6:    m = '{y0: 2'd3, u: 2'd0, y1: 2'd1, v: 2'd2};
      default: m = '{y0: 2'd2, u: 2'd1, y1: 2'd0, v: 2'd3};
    endcase
    return m;
  endfunction

  function automatic logic [7:0] pick_byte(input logic [31:0] word, input logic [1:0] pos);
    logic [7:0] b;
    case (pos)
      2'd0:    b = word[7:0];
      2'd1:    b = word[15:8];
      2'd2:    b = word[23:16];
      default: b = word[31:24];
    endcase
    return b;
  endfunction

  // Floor divide by 256, then clamp to 0..255.
  function automatic logic [7:0] sat_channel(input sum_t x);
    logic signed [SumW-9:0] q;
    logic [7:0]             r;
    q = x[SumW-1:8];
    if (q < 0) begin
      r = 8'd0;
    end else if (q > CHAN_MAX) begin
      r = 8'hFF;
    end else begin
      r = q[7:0];
    end
    return r;
  endfunction

  function automatic logic [15:0] make_pixel(input logic [7:0] y, input sum_t rv,
                                             input sum_t guv, input sum_t bu);
    sum_t       c;
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    c = ($signed({12'd0, y}) - LUMA_OFS) * COEF_Y + ROUND_OFS;
    r = sat_channel(c + rv);
    g = sat_channel(c + guv);
    b = sat_channel(c + bu);
    return {r[7:3], g[7:2], b[7:3]};
  endfunction

endpackage

`default_nettype wire

// ===== rtl/yuv422_to_rgb565_converter.sv =====
// Top level of the YUV422 macropixel to RGB565 stream converter.
`default_nettype none

// Converts one 32-bit YUV422 macropixel beat into two RGB565 pixels using
// BT.601 limited-range coefficients with 8 fractional bits (Y less 16, chroma
// less 128, rounding offset 128, floor shift, clamp to 0..255, truncate to
// 5/6/5). cfg_wr_data selects one of eight byte-lane arrangements of Y0, U,
// Y1 and V (reset value 4); write it only while the stream is idle. The block
// is a two-register pipeline: the lane select is registered at the input, the
// colour maths sits between that register and the output register. It takes
// one beat per clock sustained; an accepted input beat lands in the input register
// and then moves into the output register, which raises out_tvalid. Throughput is
// set by the single output register, which stalls the pipe only while it holds a
// beat and out_tready is low. in_tlast travels unchanged to out_tlast.
module yuv422_to_rgb565_converter (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic [2:0]  cfg_wr_data,   // byte_order
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,      // [31:0] macropixel_word
  input  wire logic        in_tlast,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,     // [15:0] first_pixel, [31:16] second_pixel
  output logic             out_tlast
);
  import yuv2rgb_pkg::*;

  logic [2:0]  byte_order_r;

  // Input stage: samples already sorted into lanes.
  logic        s1_v_r;
  logic [7:0]  s1_y0_r, s1_y1_r, s1_u_r, s1_v_byte_r;
  logic        s1_last_r;
  lane_map_t   lanes;

  logic        s2_ready;
  logic        s1_adv;
  logic        s2_load;

  sum_t        u_c, v_c, rv, guv, bu;
  logic [15:0] pix0_nxt, pix1_nxt;

  // Configuration register: reset takes priority over a write.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_order_r <= BYTE_ORDER_RESET;
    end else if (cfg_wr_en) begin
      byte_order_r <= cfg_wr_data;
    end
  end

  // Each stage advances when the one after it can take the beat.
  assign s2_ready  = !out_tvalid || out_tready;
  assign in_tready = !s1_v_r || s2_ready;
  assign s1_adv    = in_tvalid && in_tready;
  assign s2_load   = s1_v_r && s2_ready;

  assign lanes = lane_map(byte_order_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_tready) begin
      s1_v_r <= in_tvalid;
    end
  end

  // Payload: capture on acceptance, hold otherwise.
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s1_y0_r     <= pick_byte(in_tdata, lanes.y0);
      s1_y1_r     <= pick_byte(in_tdata, lanes.y1);
      s1_u_r      <= pick_byte(in_tdata, lanes.u);
      s1_v_byte_r <= pick_byte(in_tdata, lanes.v);
      s1_last_r   <= in_tlast;
    end
  end

  // Shared chroma terms, then one pixel per luma sample.
  always_comb begin
    u_c      = $signed({12'd0, s1_u_r}) - CHROMA_OFS;
    v_c      = $signed({12'd0, s1_v_byte_r}) - CHROMA_OFS;
    rv       = v_c * COEF_RV;
    guv      = -(u_c * COEF_GU) - v_c * COEF_GV;
    bu       = u_c * COEF_BU;
    pix0_nxt = make_pixel(s1_y0_r, rv, guv, bu);
    pix1_nxt = make_pixel(s1_y1_r, rv, guv, bu);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid <= 1'b0;
    end else if (s2_ready) begin
      out_tvalid <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_load) begin
      out_tdata <= {pix1_nxt, pix0_nxt};
      out_tlast <= s1_last_r;
    end
  end

  // Lane select comes out of reset at its default arrangement.
  a_cfg_reset: assert property (@(posedge clk) $rose(rst_n) |-> byte_order_r == BYTE_ORDER_RESET)
    else $error("byte_order not at reset value after reset");

  // A stalled input stage keeps its beat.
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && !s2_ready) |=> (s1_v_r && $stable(s1_y0_r) && $stable(s1_y1_r)
                               && $stable(s1_u_r) && $stable(s1_v_byte_r)))
    else $error("input stage lost or changed a stalled beat");

  // A beat moved out of the input stage shows up at the output.
  a_s2_fill: assert property (@(posedge clk) disable iff (!rst_n) s2_load |=> out_tvalid)
    else $error("beat dropped between stages");

  // An empty output register never blocks the pipe.
  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n) !out_tvalid |-> in_tready)
    else $error("pipe stalled with empty output");

endmodule

`default_nettype wire
